// ===== src/ctq_pkg.sv =====
`timescale 1ns / 1ps
// ctq_pkg: shared types, constants and point arithmetic for the contour to
// quadratic curve converter. No dependencies.
package ctq_pkg;

  localparam int COORD_BITS = 20;
  localparam int CW         = COORD_BITS + 4;
  localparam int OUT_W      = 24;
  localparam int EW         = ((CW > OUT_W) ? CW : OUT_W) + 1;
  localparam int QDEPTH     = 2;
  localparam int QPW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam logic signed [EW-1:0] SAT_HI = EW'(24'sh7FFFFF);
  localparam logic signed [EW-1:0] SAT_LO = EW'(24'sh800000);

  typedef enum logic [1:0] {
    K_CONIC = 2'd0,
    K_ON    = 2'd1,
    K_CUBIC = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SRC_FIRST = 2'd0,
    SRC_FINAL = 2'd1,
    SRC_MID   = 2'd2
  } anchor_src_t;

  typedef enum logic [1:0] {
    J_QUAD  = 2'd0,
    J_LINE  = 2'd1,
    J_CUBIC = 2'd2
  } job_kind_t;

  typedef enum logic [1:0] {
    BK_START   = 2'd0,
    BK_CUB_MID = 2'd1,
    BK_CUB_END = 2'd2
  } back_state_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } pt_t;

  // quad: (a, b, d); line: (a, mid(a,d), d); cubic: a..d are b0..b3
  typedef struct packed {
    job_kind_t kind;
    pt_t       a;
    pt_t       b;
    pt_t       c;
    pt_t       d;
  } job_t;

  typedef struct packed {
    job_t j0;
    job_t j1;
    logic two;
  } entry_t;

  function automatic kind_t norm_kind(input logic [1:0] k);
    kind_t r;
    unique case (k)
      2'd0: r = K_CONIC;
      2'd1: r = K_ON;
      2'd2: r = K_CUBIC;
      2'd3: r = K_ON;
    endcase
    return r;
  endfunction

  function automatic pt_t scale_pt(input logic [COORD_BITS-1:0] x,
                                   input logic [COORD_BITS-1:0] y);
    pt_t r;
    r.x = {x, 4'b0000};
    r.y = {y, 4'b0000};
    return r;
  endfunction

  function automatic logic signed [CW-1:0] mid_c(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    return s[CW:1];
  endfunction

  function automatic logic signed [CW-1:0] quarter_c(input logic signed [CW-1:0] e,
                                                     input logic signed [CW-1:0] c);
    logic signed [CW+2:0] s;
    s = {{3{e[CW-1]}}, e} + {{3{c[CW-1]}}, c} + {{2{c[CW-1]}}, c, 1'b0};
    return s[CW+1:2];
  endfunction

  function automatic pt_t mid_pt(input pt_t a, input pt_t b);
    pt_t r;
    r.x = mid_c(a.x, b.x);
    r.y = mid_c(a.y, b.y);
    return r;
  endfunction

  function automatic pt_t quarter_pt(input pt_t e, input pt_t c);
    pt_t r;
    r.x = quarter_c(e.x, c.x);
    r.y = quarter_c(e.y, c.y);
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [CW-1:0] v);
    logic signed [EW-1:0] e;
    logic signed [OUT_W-1:0] r;
    e = EW'(v);
    if (e > SAT_HI) begin
      r = SAT_HI[OUT_W-1:0];
    end else if (e < SAT_LO) begin
      r = SAT_LO[OUT_W-1:0];
    end else begin
      r = e[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/ctq_front.sv =====
`timescale 1ns / 1ps
// ctq_front: accepts outline points, tracks the contour walk state and
// classifies each point into up to two segment jobs. Depends on ctq_pkg.
module ctq_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ctq_pkg::COORD_BITS-1:0]   point_x,
  input  logic [ctq_pkg::COORD_BITS-1:0]   point_y,
  input  logic [1:0]                       point_kind,
  input  logic                             contour_begin,
  input  logic                             contour_end,
  input  logic [ctq_pkg::COORD_BITS-1:0]   final_x,
  input  logic [ctq_pkg::COORD_BITS-1:0]   final_y,
  input  logic [1:0]                       final_kind,
  input  logic                             q_full,
  output logic                             push,
  output ctq_pkg::entry_t                  entry
);
  import ctq_pkg::*;

  pt_t         anchor, seg, ctl, prior;
  kind_t       prior_kind;
  anchor_src_t anchor_src;

  logic        acc, single, skip, wv, cv;
  pt_t         p, f, m_pf, m_bp, anc_b, bs, bc, bp, ws, wc, wp;
  kind_t       k, fk, bk, wk;
  anchor_src_t src_b;
  job_t        wj, cj;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    p    = scale_pt(point_x, point_y);
    f    = scale_pt(final_x, final_y);
    k    = norm_kind(point_kind);
    fk   = norm_kind(final_kind);
    m_pf = mid_pt(p, f);
    m_bp = mid_pt(prior, p);

    if (contour_begin) begin
      if (k == K_ON) begin
        anc_b = p;
        src_b = SRC_FIRST;
      end else if (fk == K_ON) begin
        anc_b = f;
        src_b = SRC_FINAL;
      end else begin
        anc_b = m_pf;
        src_b = SRC_MID;
      end
      bs = anc_b;
      bc = anc_b;
      bp = anc_b;
      bk = K_ON;
    end else begin
      anc_b = anchor;
      src_b = anchor_src;
      bs    = seg;
      bc    = ctl;
      bp    = prior;
      bk    = prior_kind;
    end

    single = contour_begin && contour_end;
    skip   = (contour_begin && k == K_ON) || (contour_end && src_b == SRC_FINAL) || single;

    ws = bs;
    wc = bc;
    wp = bp;
    wk = bk;
    wv = 1'b0;
    wj = '{J_QUAD, bs, bp, bp, p};
    if (!skip) begin
      unique case (k)
        K_CUBIC: wc = bp;
        K_ON: begin
          wv = 1'b1;
          unique case (bk)
            K_CUBIC: wj = '{J_CUBIC, bs, bc, bp, p};
            K_ON:    wj = '{J_LINE, bp, bp, bp, p};
            K_CONIC: wj = '{J_QUAD, bs, bp, bp, p};
          endcase
          ws = p;
          wc = p;
        end
        K_CONIC: begin
          // a fresh anchor counts as an on-curve prior, so a conic right after it makes no curve
          if (bk != K_ON) begin
            wv = 1'b1;
            wj = '{J_QUAD, bs, bp, bp, m_bp};
            ws = m_bp;
            wc = m_bp;
          end
        end
      endcase
      wp = p;
      wk = k;
    end

    cv = contour_end && !single;
    unique case (wk)
      K_CUBIC: cj = '{J_CUBIC, ws, wc, wp, anc_b};
      K_ON:    cj = '{J_LINE, wp, wp, wp, anc_b};
      K_CONIC: cj = '{J_QUAD, ws, wp, wp, anc_b};
    endcase

    entry.j0  = wv ? wj : cj;
    entry.j1  = cj;
    entry.two = wv && cv;
    push      = acc && (wv || cv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor     <= '0;
      seg        <= '0;
      ctl        <= '0;
      prior      <= '0;
      prior_kind <= K_ON;
      anchor_src <= SRC_FIRST;
    end else if (acc) begin
      anchor     <= anc_b;
      seg        <= ws;
      ctl        <= wc;
      prior      <= wp;
      prior_kind <= wk;
      anchor_src <= src_b;
    end
  end

endmodule

// ===== src/ctq_queue.sv =====
`timescale 1ns / 1ps
// ctq_queue: short word queue between front and back.
// Depends on ctq_pkg.
module ctq_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ctq_pkg::entry_t wdata,
  output logic            full,
  output logic            valid,
  input  logic            pop,
  output ctq_pkg::entry_t rdata
);
  import ctq_pkg::*;

  entry_t           slots [QDEPTH];
  logic [QPW-1:0]   wptr, rptr;
  logic [QPW:0]     count;

  assign full  = (count == (QPW+1)'(QDEPTH));
  assign valid = (count != '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/ctq_back.sv =====
`timescale 1ns / 1ps
// ctq_back: expands segment jobs into quadratic curves and holds them in the
// output register. Depends on ctq_pkg.
module ctq_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  ctq_pkg::entry_t                   head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ctq_pkg::OUT_W-1:0]  p0_x,
  output logic signed [ctq_pkg::OUT_W-1:0]  p0_y,
  output logic signed [ctq_pkg::OUT_W-1:0]  p1_x,
  output logic signed [ctq_pkg::OUT_W-1:0]  p1_y,
  output logic signed [ctq_pkg::OUT_W-1:0]  p2_x,
  output logic signed [ctq_pkg::OUT_W-1:0]  p2_y,
  output logic                              run_last
);
  import ctq_pkg::*;

  back_state_t state, state_next;
  logic        sel, sel_next;
  pt_t         c0, c1, dm;

  job_t        job;
  logic        last_job, load, emit, cap, done, dm_en, elast;
  pt_t         q0, q1, mid_l, mid_r, mo, e0, e1, e2;

  assign job      = sel ? head.j1 : head.j0;
  assign last_job = sel || !head.two;
  assign load     = !out_valid || out_ready;
  assign q0       = quarter_pt(job.a, job.b);
  assign q1       = quarter_pt(job.d, job.c);
  assign mid_l    = (state == BK_CUB_MID) ? c0 : job.a;
  assign mid_r    = (state == BK_CUB_MID) ? c1 : job.d;
  assign mo       = mid_pt(mid_l, mid_r);

  always_comb begin
    state_next = state;
    sel_next   = sel;
    q_pop      = 1'b0;
    emit       = 1'b0;
    cap        = 1'b0;
    done       = 1'b0;
    dm_en      = 1'b0;
    e0         = job.a;
    e1         = job.b;
    e2         = job.d;
    unique case (state)
      BK_START: begin
        if (q_valid) begin
          case (job.kind)
            J_CUBIC: begin
              cap        = 1'b1;
              state_next = BK_CUB_MID;
            end
            J_LINE: begin
              if (load) begin
                emit = 1'b1;
                e1   = mo;
                done = 1'b1;
              end
            end
            J_QUAD: begin
              if (load) begin
                emit = 1'b1;
                done = 1'b1;
              end
            end
            default: done = 1'b0;
          endcase
        end
      end
      BK_CUB_MID: begin
        if (load) begin
          emit       = 1'b1;
          dm_en      = 1'b1;
          e1         = c0;
          e2         = mo;
          state_next = BK_CUB_END;
        end
      end
      BK_CUB_END: begin
        if (load) begin
          emit = 1'b1;
          e0   = dm;
          e1   = c1;
          done = 1'b1;
        end
      end
      default: state_next = BK_START;
    endcase
    if (done) begin
      state_next = BK_START;
      if (last_job) begin
        q_pop    = 1'b1;
        sel_next = 1'b0;
      end else begin
        sel_next = 1'b1;
      end
    end
    elast = done && last_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_START;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      c0 <= q0;
      c1 <= q1;
    end
    if (dm_en) begin
      dm <= mo;
    end
    if (emit) begin
      p0_x     <= sat_out(e0.x);
      p0_y     <= sat_out(e0.y);
      p1_x     <= sat_out(e1.x);
      p1_y     <= sat_out(e1.y);
      p2_x     <= sat_out(e2.x);
      p2_y     <= sat_out(e2.y);
      run_last <= elast;
    end
  end

endmodule

// ===== src/contour_to_quadratic_curves_top.sv =====
`timescale 1ns / 1ps
// Contour points in, closed quadratic Bezier curves out (1/16 font units).
// The front classifies points into segment jobs; a two-word queue feeds the
// back, which builds the curves. A point's curves pass through the queue and
// the output register; a cubic segment first has its quarter points
// registered. The front takes one point per cycle while the queue has room.
// The back builds a line or conic curve directly and splits a cubic segment
// by registering its quarter points, then emitting one half and then the
// other; a point gives up to two segment jobs. Curves leave
// from an output register; the back stalls only while a finished word waits
// and refills the register in the cycle it is taken. Depends on ctq_pkg,
// ctq_front, ctq_queue and ctq_back.
module contour_to_quadratic_curves_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ctq_pkg::COORD_BITS-1:0]    point_x,
  input  logic [ctq_pkg::COORD_BITS-1:0]    point_y,
  input  logic [1:0]                        point_kind,
  input  logic                              contour_begin,
  input  logic                              contour_end,
  input  logic [ctq_pkg::COORD_BITS-1:0]    final_x,
  input  logic [ctq_pkg::COORD_BITS-1:0]    final_y,
  input  logic [1:0]                        final_kind,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ctq_pkg::OUT_W-1:0]  p0_x,
  output logic signed [ctq_pkg::OUT_W-1:0]  p0_y,
  output logic signed [ctq_pkg::OUT_W-1:0]  p1_x,
  output logic signed [ctq_pkg::OUT_W-1:0]  p1_y,
  output logic signed [ctq_pkg::OUT_W-1:0]  p2_x,
  output logic signed [ctq_pkg::OUT_W-1:0]  p2_y,
  output logic                              run_last
);
  import ctq_pkg::*;

  logic   push, q_full, q_valid, q_pop;
  entry_t wdata, rdata;

  ctq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_kind    (point_kind),
    .contour_begin (contour_begin),
    .contour_end   (contour_end),
    .final_x       (final_x),
    .final_y       (final_y),
    .final_kind    (final_kind),
    .q_full        (q_full),
    .push          (push),
    .entry         (wdata)
  );

  ctq_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .rdata (rdata)
  );

  ctq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .p0_x      (p0_x),
    .p0_y      (p0_y),
    .p1_x      (p1_x),
    .p1_y      (p1_y),
    .p2_x      (p2_x),
    .p2_y      (p2_y),
    .run_last  (run_last)
  );

endmodule

// ===== src/ctq_checker.sv =====
`timescale 1ns / 1ps
// ctq_checker: port-level checks on the converter top level, bound to it.
// Depends on ctq_pkg and contour_to_quadratic_curves_top.
module ctq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ctq_pkg::OUT_W-1:0]  p0_x,
  input logic signed [ctq_pkg::OUT_W-1:0]  p0_y,
  input logic signed [ctq_pkg::OUT_W-1:0]  p1_x,
  input logic signed [ctq_pkg::OUT_W-1:0]  p1_y,
  input logic signed [ctq_pkg::OUT_W-1:0]  p2_x,
  input logic signed [ctq_pkg::OUT_W-1:0]  p2_y,
  input logic                              run_last
);
  import ctq_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(p0_x) && $stable(p0_y) &&
      $stable(p1_x) && $stable(p1_y) && $stable(p2_x) && $stable(p2_y) &&
      $stable(run_last))
    else $error("stalled output word changed");

  // the queue only fills through accepted words
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(in_valid && in_ready) || $past(!in_ready))
    else $error("input stalled without a prior word");

endmodule

bind contour_to_quadratic_curves_top ctq_checker u_ctq_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for contour_to_quadratic_curves_top. A directed table,
// then random contours under varying idle rates, checked against an in-bench predictor.
// Depends on ctq_pkg and the RTL top.
module tb;
  import ctq_pkg::*;

  localparam logic [1:0] KIND_ALIAS_ON = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [1:0]            kind;
    logic                  cbegin;
    logic                  cend;
    logic [COORD_BITS-1:0] fx;
    logic [COORD_BITS-1:0] fy;
    logic [1:0]            fkind;
  } pt_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] p0x;
    logic [OUT_W-1:0] p0y;
    logic [OUT_W-1:0] p1x;
    logic [OUT_W-1:0] p1y;
    logic [OUT_W-1:0] p2x;
    logic [OUT_W-1:0] p2y;
    logic             fin;
  } curve_t;

  // n < 0: expectation from the predictor, else n curves typed in a, b
  typedef struct packed {
    pt_word_t w;
    int       n;
    curve_t   a;
    curve_t   b;
  } row_t;

  typedef struct packed {
    longint x;
    longint y;
  } xy_t;

  localparam curve_t NOC = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD_BITS-1:0] point_x = '0, point_y = '0, final_x = '0, final_y = '0;
  logic [1:0] point_kind = '0, final_kind = '0;
  logic contour_begin = 1'b0, contour_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y;
  logic run_last;

  int tx_idle = 0;
  int rx_idle = 0;
  int err_cnt = 0;

  curve_t curves_due[$];
  curve_t calc[$];

  xy_t anc, seg, cub, prv;
  kind_t prv_k = K_ON;
  anchor_src_t src = SRC_FIRST;

  contour_to_quadratic_curves_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .point_kind(point_kind),
    .contour_begin(contour_begin), .contour_end(contour_end),
    .final_x(final_x), .final_y(final_y), .final_kind(final_kind),
    .out_valid(out_valid), .out_ready(out_ready),
    .p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y), .p2_x(p2_x), .p2_y(p2_y),
    .run_last(run_last)
  );

  always #5 clk = ~clk;

  always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle);

  // ---------------- predictor ----------------
  function automatic longint floor_div(input longint s, input int sh);
    longint d;
    d = longint'(1) << sh;
    return (s - (s & (d - 1))) / d;
  endfunction

  function automatic xy_t midp(input xy_t a, input xy_t b);
    xy_t r;
    r.x = floor_div(a.x + b.x, 1);
    r.y = floor_div(a.y + b.y, 1);
    return r;
  endfunction

  function automatic xy_t qtr(input xy_t e, input xy_t c);
    xy_t r;
    r.x = floor_div(e.x + 3 * c.x, 2);
    r.y = floor_div(e.y + 3 * c.y, 2);
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] clamp24(input longint v);
    longint lim_hi, lim_lo;
    lim_hi = (longint'(1) << (OUT_W - 1)) - 1;
    lim_lo = -(longint'(1) << (OUT_W - 1));
    if (v > lim_hi) v = lim_hi;
    if (v < lim_lo) v = lim_lo;
    return v[OUT_W-1:0];
  endfunction

  function automatic xy_t scaled(input logic [COORD_BITS-1:0] x,
                                 input logic [COORD_BITS-1:0] y);
    xy_t r;
    r.x = longint'($signed(x)) * 16;
    r.y = longint'($signed(y)) * 16;
    return r;
  endfunction

  // bit 0 set means on-curve, so the alias kind folds onto K_ON
  function automatic kind_t nkind(input logic [1:0] k);
    if (k[0]) return K_ON;
    return kind_t'(k);
  endfunction

  task automatic emit(input xy_t a, input xy_t b, input xy_t c);
    curve_t cv;
    if (calc.size() < 4) begin
      cv.p0x = clamp24(a.x); cv.p0y = clamp24(a.y);
      cv.p1x = clamp24(b.x); cv.p1y = clamp24(b.y);
      cv.p2x = clamp24(c.x); cv.p2y = clamp24(c.y);
      cv.fin = 1'b0;
      calc.insert(calc.size(), cv);
    end
  endtask

  task automatic emit_split_cubic(input xy_t b3);
    xy_t c0, c1, d;
    c0 = qtr(seg, cub);
    c1 = qtr(b3, prv);
    d  = midp(c0, c1);
    emit(seg, c0, d);
    emit(d, c1, b3);
  endtask

  task automatic close_to(input xy_t e);
    if (prv_k == K_CUBIC) begin
      emit_split_cubic(e);
    end else if (prv_k == K_ON) begin
      emit(prv, midp(prv, e), e);
    end else begin
      emit(seg, prv, e);
    end
  endtask

  task automatic walk_point(input xy_t p, input kind_t k);
    xy_t m;
    if (k == K_CUBIC) begin
      cub = prv;
    end else if (k == K_ON) begin
      close_to(p);
      seg = p;
      cub = p;
    end else if (prv_k != K_ON) begin
      m = midp(prv, p);
      emit(seg, prv, m);
      seg = m;
      cub = m;
    end
    prv = p;
    prv_k = k;
  endtask

  task automatic predict_curves(input pt_word_t w);
    xy_t p, f;
    kind_t k, fk;
    logic skip;
    calc.delete();
    p = scaled(w.px, w.py);
    k = nkind(w.kind);
    skip = 1'b0;
    if (w.cbegin) begin
      f = scaled(w.fx, w.fy);
      fk = nkind(w.fkind);
      if (k == K_ON) begin
        anc = p;
        src = SRC_FIRST;
        skip = 1'b1;
      end else if (fk == K_ON) begin
        anc = f;
        src = SRC_FINAL;
      end else begin
        anc = midp(p, f);
        src = SRC_MID;
      end
      seg = anc;
      cub = anc;
      prv = anc;
      prv_k = K_ON;
    end
    if (!(w.cbegin && w.cend)) begin
      if (w.cend && src == SRC_FINAL) skip = 1'b1;
      if (!skip) walk_point(p, k);
      if (w.cend) close_to(anc);
      if (calc.size() > 0) calc[calc.size() - 1].fin = 1'b1;
    end
  endtask

  // ---------------- driving ----------------
  task automatic send_word(input row_t r);
    while ($urandom_range(99) < tx_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    point_x = r.w.px;
    point_y = r.w.py;
    point_kind = r.w.kind;
    contour_begin = r.w.cbegin;
    contour_end = r.w.cend;
    final_x = r.w.fx;
    final_y = r.w.fy;
    final_kind = r.w.fkind;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_curves(r.w);
    if (r.n < 0) begin
      foreach (calc[i]) curves_due.insert(curves_due.size(), calc[i]);
    end else begin
      if (r.n > 0) curves_due.insert(curves_due.size(), r.a);
      if (r.n > 1) curves_due.insert(curves_due.size(), r.b);
    end
    @(negedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] rnd_coord();
    if ($urandom_range(7) == 0) return COORD_BITS'($urandom);
    return COORD_BITS'(int'($urandom_range(4095)) - 2048);
  endfunction

  function automatic logic [1:0] rnd_kind();
    int r;
    r = $urandom_range(99);
    if (r < 40) return K_ON;
    if (r < 70) return K_CONIC;
    if (r < 95) return K_CUBIC;
    return KIND_ALIAS_ON;
  endfunction

  task automatic run_phase(input int tx, input int rx, input int n_items);
    pt_word_t pts[8];
    row_t r;
    int sent, len;
    tx_idle = tx;
    rx_idle = rx;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        // stray word: any flags, any kinds
        pts[0] = '{rnd_coord(), rnd_coord(), 2'($urandom), 1'($urandom), 1'($urandom),
                   rnd_coord(), rnd_coord(), 2'($urandom)};
        len = 1;
      end else begin
        len = ($urandom_range(3) == 0) ? $urandom_range(8, 1) : $urandom_range(5, 2);
        for (int i = 0; i < len; i++) begin
          pts[i] = '0;
          pts[i].px = rnd_coord();
          pts[i].py = rnd_coord();
          pts[i].kind = rnd_kind();
          pts[i].fx = rnd_coord();
          pts[i].fy = rnd_coord();
          pts[i].fkind = 2'($urandom);
        end
        pts[0].cbegin = 1'b1;
        pts[0].fx = pts[len-1].px;
        pts[0].fy = pts[len-1].py;
        pts[0].fkind = pts[len-1].kind;
        pts[len-1].cend = 1'b1;
      end
      for (int i = 0; i < len; i++) begin
        r = '{pts[i], -1, NOC, NOC};
        send_word(r);
      end
      sent += len;
    end
  endtask

  function automatic pt_word_t pw(input int x, input int y, input logic [1:0] k,
                                  input logic b, input logic e,
                                  input int fx, input int fy, input logic [1:0] fk);
    return '{COORD_BITS'(x), COORD_BITS'(y), k, b, e, COORD_BITS'(fx), COORD_BITS'(fy), fk};
  endfunction

  function automatic curve_t cv(input int ax, input int ay, input int bx, input int by,
                                input int cx, input int cy, input logic fin);
    return '{OUT_W'(ax), OUT_W'(ay), OUT_W'(bx), OUT_W'(by), OUT_W'(cx), OUT_W'(cy), fin};
  endfunction

  // ---------------- checking ----------------
  task automatic chk(input string name, input logic [OUT_W-1:0] e, input logic [OUT_W-1:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(e), $signed(a));
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    curve_t e;
    if (!rst && out_valid && out_ready) begin
      if (curves_due.size() == 0) begin
        $error("unexpected curve word: p0=(%0d,%0d)", p0_x, p0_y);
        err_cnt++;
      end else begin
        e = curves_due.pop_front();
        chk("p0_x", e.p0x, p0_x);
        chk("p0_y", e.p0y, p0_y);
        chk("p1_x", e.p1x, p1_x);
        chk("p1_y", e.p1y, p1_y);
        chk("p2_x", e.p2x, p2_x);
        chk("p2_y", e.p2y, p2_y);
        chk("run_last", OUT_W'(e.fin), OUT_W'(run_last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    row_t dir[$];
    dir.insert(dir.size(), '{pw(1, 1, K_ON, 0, 0, 0, 0, K_ON), 1, cv(0, 0, 8, 8, 16, 16, 1),
                             NOC});
    dir.insert(dir.size(), '{pw(-524288, -524288, K_ON, 1, 0, 0, 0, K_CONIC), 0, NOC, NOC});
    dir.insert(dir.size(), '{pw(524287, 524287, K_ON, 0, 1, 0, 0, K_ON), 2,
                             cv(-8388608, -8388608, -8, -8, 8388592, 8388592, 0),
                             cv(8388592, 8388592, -8, -8, -8388608, -8388608, 1)});
    dir.insert(dir.size(), '{pw(5, 5, K_CONIC, 1, 1, 7, 7, K_CONIC), 0, NOC, NOC});
    // conic start, on-curve final point as anchor
    dir.insert(dir.size(), '{pw(10, 0, K_CONIC, 1, 0, 0, 0, K_ON), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(20, 10, K_CONIC, 0, 0, 0, 0, K_ON), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(0, 0, K_ON, 0, 1, 0, 0, K_ON), -1, NOC, NOC});
    // all conic, midpoint anchor
    dir.insert(dir.size(), '{pw(0, 0, K_CONIC, 1, 0, 0, 100, K_CONIC), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(100, 0, K_CONIC, 0, 0, 0, 0, K_ON), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(100, 100, K_CONIC, 0, 0, 0, 0, K_ON), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(0, 100, K_CONIC, 0, 1, 0, 0, K_ON), -1, NOC, NOC});
    // cubic segments, closing through a cubic
    dir.insert(dir.size(), '{pw(0, 0, K_ON, 1, 0, -3, 3, K_CUBIC), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(10, 20, K_CUBIC, 0, 0, 0, 0, K_ON), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(30, 20, K_CUBIC, 0, 0, 0, 0, K_ON), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(40, 0, K_ON, 0, 0, 0, 0, K_ON), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(-5, -7, K_CUBIC, 0, 0, 0, 0, K_ON), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(-3, 3, K_CUBIC, 0, 1, 0, 0, K_ON), -1, NOC, NOC});
    // conic right after a cubic control
    dir.insert(dir.size(), '{pw(0, 0, K_ON, 1, 0, 4, -4, K_ON), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(8, 8, K_CUBIC, 0, 0, 0, 0, K_ON), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(16, 0, K_CONIC, 0, 0, 0, 0, K_ON), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(4, -4, K_ON, 0, 1, 0, 0, K_ON), -1, NOC, NOC});
    // alias kind treated as on-curve
    dir.insert(dir.size(), '{pw(1, 2, KIND_ALIAS_ON, 1, 0, 0, 0, K_CONIC), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(-1, -3, KIND_ALIAS_ON, 0, 1, 0, 0, K_ON), -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(524287, -524288, K_CONIC, 1, 0, -524288, 524287, K_CUBIC),
                             -1, NOC, NOC});
    dir.insert(dir.size(), '{pw(-1, -1, K_CONIC, 0, 1, 0, 0, K_ON), -1, NOC, NOC});

    repeat (6) @(negedge clk);
    rst = 1'b0;

    tx_idle = 28;
    rx_idle = 52;
    foreach (dir[i]) send_word(dir[i]);

    run_phase(28, 52, 50);
    // hold off until the block has drained
    in_valid = 1'b0;
    while (curves_due.size() != 0) @(negedge clk);
    run_phase(52, 28, 50);
    in_valid = 1'b0;
    while (curves_due.size() != 0) @(negedge clk);
    run_phase(0, 0, 50);

    in_valid = 1'b0;
    while (curves_due.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ctq_pkg.sv
src/ctq_front.sv
src/ctq_queue.sv
src/ctq_back.sv
src/contour_to_quadratic_curves_top.sv
src/ctq_checker.sv
dv/tb.sv
